// ----- rtl/csp_pkg.sv -----
// Shared types and constants of the Chebyshev series product block.
package csp_pkg;

  localparam int COEF_W     = 32;
  localparam int DEG_W      = 4;
  localparam int IDX_W      = 5;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int ACC_W      = 72;
  localparam int FRAC_SHIFT = 25;

  localparam logic [DEG_W-1:0]  DEGREE_RESET = DEG_W'(14);
  localparam logic [ACC_W-1:0]  ROUND_BIAS   = ACC_W'(1) << (FRAC_SHIFT - 1);
  localparam logic [COEF_W-1:0] SAT_POS      = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] SAT_NEG      = {1'b1, {(COEF_W-1){1'b0}}};

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_f;
    logic signed [COEF_W-1:0] coef_g;
  } coef_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]         product_index;
    logic signed [COEF_W-1:0] product_coef;
    logic                     saturated;
    logic                     last_result;
  } coef_out_t;

  // Tag that travels with each product through the multiply pipeline.
  typedef struct packed {
    logic             valid;
    logic             first;
    logic             last_term;
    logic             last_coef;
    logic [IDX_W-1:0] idx;
  } term_tag_t;

endpackage

// ----- rtl/chebyshev_series_product.sv -----
// Top level of the Chebyshev series product block.
//
// Usage: write degree through cfg_we/cfg_data while the block is idle, then send
// the coefficient pairs (f_k, g_k) for k = 0..D one word per accepted start
// (start high while busy is low). D is degree, clamped to MAX_DEGREE.
// Pairs are taken back to back, one per cycle, into two coefficient RAMs.
// The word that completes the set raises busy. A sequencer then feeds one
// product f_i*g_j per cycle from the RAMs into a single multiply-accumulate;
// that one multiplier sets the rate. The last product passes the RAM read
// register, the product register and the accumulator to the result register.
// The 2*D+1 coefficients appear in index order, each for one cycle with
// result_strobe high; the receiver cannot stall, so no result is held back.
// busy falls the cycle after the word flagged last_result, and from then on
// the pairs of the next set can be accepted.
// Reset is synchronous: it returns to loading at index 0 with degree 14 and
// raises busy while it is asserted; the RAM contents are not cleared.
module chebyshev_series_product #(
  parameter int MAX_DEGREE = 15
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  csp_pkg::coef_in_t         operand,
  input  logic                      cfg_we,
  input  logic [csp_pkg::DEG_W-1:0] cfg_data,
  output logic                      result_strobe,
  output csp_pkg::coef_out_t        result
);
  import csp_pkg::*;

  localparam int DEPTH = MAX_DEGREE + 1;
  localparam int AW    = $clog2(DEPTH);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     rd_addr_f;
  logic [AW-1:0]     rd_addr_g;
  logic [COEF_W-1:0] f_data;
  logic [COEF_W-1:0] g_data;
  logic              set_done;
  term_tag_t         tag;

  assign set_done = result_strobe && result.last_result;

  csp_seq #(
    .MAX_DEGREE (MAX_DEGREE),
    .AW         (AW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .set_done  (set_done),
    .busy      (busy),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .rd_addr_f (rd_addr_f),
    .rd_addr_g (rd_addr_g),
    .tag       (tag)
  );

  csp_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_ram_f (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (operand.coef_f),
    .raddr (rd_addr_f),
    .rdata (f_data)
  );

  csp_ram #(
    .WIDTH (COEF_W),
    .DEPTH (DEPTH)
  ) u_ram_g (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (operand.coef_g),
    .raddr (rd_addr_g),
    .rdata (g_data)
  );

  csp_mac u_mac (
    .clk           (clk),
    .rst           (rst),
    .tag           (tag),
    .f_data        (f_data),
    .g_data        (g_data),
    .result_strobe (result_strobe),
    .result        (result)
  );

endmodule

// ----- rtl/csp_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module csp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/csp_seq.sv -----
// Load control and term sequencer: walks the index pairs of every product coefficient.
module csp_seq #(
  parameter int MAX_DEGREE = 15,
  parameter int AW         = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      cfg_we,
  input  logic [csp_pkg::DEG_W-1:0] cfg_data,
  input  logic                      set_done,
  output logic                      busy,
  output logic                      wr_en,
  output logic [AW-1:0]             wr_addr,
  output logic [AW-1:0]             rd_addr_f,
  output logic [AW-1:0]             rd_addr_g,
  output csp_pkg::term_tag_t        tag
);
  import csp_pkg::*;

  localparam logic [1:0] S_LOAD  = 2'd0;
  localparam logic [1:0] S_RUN   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;

  logic [1:0]       state;
  logic [DEG_W-1:0] degree;
  logic [DEG_W-1:0] d_eff;
  logic [DEG_W-1:0] d_run;
  logic [IDX_W-1:0] load_count;
  logic [IDX_W-1:0] n;
  logic [IDX_W-1:0] i;
  logic             phase_b;
  logic             mirror;
  logic             first;

  logic             accept;
  logic             complete;
  logic [IDX_W-1:0] dw;
  logic [IDX_W-1:0] top;
  logic [IDX_W-1:0] hi_n;
  logic [IDX_W-1:0] n_inc;
  logic [IDX_W-1:0] lo_next;
  logic [IDX_W-1:0] f_idx;
  logic [IDX_W-1:0] g_idx;
  logic             last_term;

  assign busy     = rst || (state != S_LOAD);
  assign accept   = start && !busy;
  assign d_eff    = ({1'b0, degree} > IDX_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree;
  assign complete = load_count >= {1'b0, d_eff};

  assign wr_en   = accept;
  assign wr_addr = (load_count <= IDX_W'(MAX_DEGREE)) ? load_count[AW-1:0] : AW'(MAX_DEGREE);

  assign dw      = {1'b0, d_run};
  assign top     = {d_run, 1'b0};
  assign n_inc   = n + IDX_W'(1);
  assign lo_next = (n_inc > dw) ? (n_inc - dw) : '0;

  // Coefficient zero sums the diagonal in the first phase and adds f0*g0 once more in the
  // second; other coefficients take sum pairs, then both difference pairs if n <= D.
  always_comb begin
    hi_n = (n == '0) ? dw : ((n < dw) ? n : dw);
    if (!phase_b) begin
      f_idx = i;
      g_idx = (n == '0) ? i : (n - i);
    end else begin
      f_idx = mirror ? (i - n) : i;
      g_idx = mirror ? i : (i - n);
    end
    if (phase_b) begin
      last_term = (n == '0) || (mirror && (i == dw));
    end else begin
      last_term = (n != '0) && (n > dw) && (i == hi_n);
    end
  end

  assign rd_addr_f     = f_idx[AW-1:0];
  assign rd_addr_g     = g_idx[AW-1:0];
  assign tag.valid     = (state == S_RUN);
  assign tag.first     = first;
  assign tag.last_term = last_term;
  assign tag.last_coef = (n == top);
  assign tag.idx       = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      degree     <= DEGREE_RESET;
      load_count <= '0;
      d_run      <= '0;
      n          <= '0;
      i          <= '0;
      phase_b    <= 1'b0;
      mirror     <= 1'b0;
      first      <= 1'b0;
    end else begin
      if (cfg_we) begin
        degree <= cfg_data;
      end
      unique case (state)
        S_LOAD: begin
          if (accept) begin
            if (complete) begin
              load_count <= '0;
              d_run      <= d_eff;
              n          <= '0;
              i          <= '0;
              phase_b    <= 1'b0;
              mirror     <= 1'b0;
              first      <= 1'b1;
              state      <= S_RUN;
            end else begin
              load_count <= load_count + IDX_W'(1);
            end
          end
        end
        S_RUN: begin
          if (last_term) begin
            if (n == top) begin
              state <= S_DRAIN;
              first <= 1'b0;
            end else begin
              n       <= n_inc;
              i       <= lo_next;
              phase_b <= 1'b0;
              mirror  <= 1'b0;
              first   <= 1'b1;
            end
          end else begin
            first <= 1'b0;
            if (!phase_b) begin
              if (i == hi_n) begin
                phase_b <= 1'b1;
                i       <= n;
                mirror  <= 1'b0;
              end else begin
                i <= i + IDX_W'(1);
              end
            end else if (!mirror) begin
              mirror <= 1'b1;
            end else begin
              i      <= i + IDX_W'(1);
              mirror <= 1'b0;
            end
          end
        end
        S_DRAIN: begin
          if (set_done) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

endmodule

// ----- rtl/csp_mac.sv -----
// Multiply-accumulate pipeline with rounding and saturation of each product coefficient.
module csp_mac (
  input  logic                       clk,
  input  logic                       rst,
  input  csp_pkg::term_tag_t         tag,
  input  logic [csp_pkg::COEF_W-1:0] f_data,
  input  logic [csp_pkg::COEF_W-1:0] g_data,
  output logic                       result_strobe,
  output csp_pkg::coef_out_t         result
);
  import csp_pkg::*;

  localparam int SIGN_BITS = ACC_W - FRAC_SHIFT - COEF_W + 1;

  term_tag_t                tag1;
  term_tag_t                tag2;
  term_tag_t                tag3;
  logic signed [PROD_W-1:0] prod;
  logic [ACC_W-1:0]         acc;
  logic [ACC_W-1:0]         acc_next;
  logic [ACC_W-1:0]         rnd;
  logic                     fits;

  assign acc_next = (tag2.first ? '0 : acc) + {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
  assign rnd      = acc + ROUND_BIAS;
  // The rounded value fits in 32 bits when every bit above its sign agrees with it.
  assign fits     = rnd[ACC_W-1:FRAC_SHIFT+COEF_W-1]
                    == {SIGN_BITS{rnd[FRAC_SHIFT+COEF_W-1]}};

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1          <= '0;
      tag2          <= '0;
      tag3          <= '0;
      acc           <= '0;
      result_strobe <= 1'b0;
    end else begin
      tag1          <= tag;
      tag2          <= tag1;
      tag3          <= tag2;
      result_strobe <= tag3.valid && tag3.last_term;
      if (tag2.valid) begin
        acc <= acc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed(f_data) * $signed(g_data);
    if (tag3.valid && tag3.last_term) begin
      result.product_index <= tag3.idx;
      result.product_coef  <= fits ? rnd[FRAC_SHIFT+COEF_W-1:FRAC_SHIFT]
                                   : (rnd[ACC_W-1] ? SAT_NEG : SAT_POS);
      result.saturated     <= !fits;
      result.last_result   <= tag3.last_coef;
    end
  end

endmodule

// ----- rtl/csp_checker.sv -----
// Port-level assertions for the Chebyshev series product block, bound to its top level.
module csp_checker (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input csp_pkg::coef_out_t result,
  input logic               result_strobe
);

  // Results only come out while a set is being computed.
  a_no_result_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !result_strobe)
    else $error("result word while idle");

  a_busy_mid_set: assert property (@(posedge clk) disable iff (rst)
    result_strobe && !result.last_result |=> busy)
    else $error("busy dropped before the last coefficient");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.last_result |=> !busy)
    else $error("busy held after the last coefficient");

  // Only an accepted word can start the computation.
  a_busy_needs_start: assert property (@(posedge clk) disable iff (rst)
    !busy && !start |=> !busy)
    else $error("busy rose without an accepted word");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    result_strobe && result.saturated |->
      (result.product_coef == 32'sh7FFFFFFF) || (result.product_coef == 32'sh80000000))
    else $error("saturated word does not hold a limit value");

endmodule

bind chebyshev_series_product csp_checker u_csp_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result        (result),
  .result_strobe (result_strobe)
);
